// ----- rtl/round_robin_burst_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Round-robin burst scheduler assertion macros
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_BURST_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_BURST_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define RRBS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrbs assertion failed");
`define RRBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrbs assertion failed");
`else
`define RRBS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RRBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/rrbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrbs_pkg
// Shared types, widths and codes of the round-robin burst scheduler.
// ----------------------------------------------------------------------------
package rrbs_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   localparam int BURST_W   = 16;
   localparam int QUANTUM_W = 16;
   localparam int PID_W     = 6;
   localparam int WAIT_W    = 32;
   localparam int ELAPSED_W = 22;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM    = 1'd1;

   localparam logic                 MODE_FCFS     = 1'b0;
   localparam logic                 MODE_RESET    = 1'b1;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic               last_proc;
   } req_type;

   typedef struct packed {
      logic [PID_W-1:0]     pid;
      logic [WAIT_W-1:0]    wait_total;
      logic [ELAPSED_W-1:0] elapsed;
      logic                 last_result;
   } rsp_type;

   typedef struct packed {
      logic load;      // store the incoming burst
      logic start;     // clear elapsed time, search from entry 0
      logic pick;      // latch the next unfinished entry
      logic run;       // run one slice of the current entry
      logic emit;      // load the result register
      logic clear;     // batch done, empty the store
   } cmd_type;

   typedef struct packed {
      logic found;     // some unfinished entry remains
      logic out_free;  // result register can take a new item
      logic last_idx;  // next result is the final one
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PICK = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

// ----- rtl/rrbs_dp.sv -----
// ----------------------------------------------------------------------------
// rrbs_dp
// Datapath: burst and wait stores, next-entry search, slice arithmetic,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`include "round_robin_burst_scheduler_defines.svh"

module rrbs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rrbs_pkg::req_type                   req_data,
   input  rrbs_pkg::cmd_type                   cmd,
   output rrbs_pkg::status_type                status,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output rrbs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [rrbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rrbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [rrbs_pkg::BURST_W-1:0]   rem_ff   [rrbs_pkg::MAX_PROCS];
   logic [rrbs_pkg::BURST_W-1:0]   rem_in   [rrbs_pkg::MAX_PROCS];
   logic [rrbs_pkg::WAIT_W-1:0]    wait_ff  [rrbs_pkg::MAX_PROCS];
   logic [rrbs_pkg::WAIT_W-1:0]    wait_in  [rrbs_pkg::MAX_PROCS];
   logic [rrbs_pkg::WAIT_W:0]      wait_sum [rrbs_pkg::MAX_PROCS];

   logic [rrbs_pkg::CNT_W-1:0]     count_ff,   count_in;
   logic [rrbs_pkg::IDX_W-1:0]     cur_ff,     cur_in;
   logic [rrbs_pkg::IDX_W-1:0]     start_ff,   start_in;
   logic [rrbs_pkg::IDX_W-1:0]     out_idx_ff, out_idx_in;
   logic [rrbs_pkg::ELAPSED_W-1:0] clk_ff,     clk_in;
   logic                           mode_ff,    mode_in;
   logic [rrbs_pkg::QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rrbs_pkg::rsp_type              rsp_ff,     rsp_in;

   logic [rrbs_pkg::MAX_PROCS-1:0] active;
   logic                           found;
   logic [rrbs_pkg::IDX_W-1:0]     found_idx;
   logic [rrbs_pkg::QUANTUM_W-1:0] q_eff;
   logic [rrbs_pkg::BURST_W-1:0]   cur_rem;
   logic [rrbs_pkg::BURST_W-1:0]   amt;
   logic [rrbs_pkg::IDX_W-1:0]     next_start;
   logic                           last_idx;

   // entry still has work to do
   always_comb begin
      for (int i = 0; i < rrbs_pkg::MAX_PROCS; i++) begin
         active[i] = (rrbs_pkg::CNT_W'(i) < count_ff) && (rem_ff[i] != '0);
      end
   end

   // cyclic first-set search starting at start_ff
   always_comb begin
      int pos;
      found     = 1'b0;
      found_idx = '0;
      for (int k = rrbs_pkg::MAX_PROCS - 1; k >= 0; k--) begin
         pos = int'(start_ff) + k;
         if (pos >= rrbs_pkg::MAX_PROCS) begin
            pos = pos - rrbs_pkg::MAX_PROCS;
         end
         if (active[rrbs_pkg::IDX_W'(pos)]) begin
            found     = 1'b1;
            found_idx = rrbs_pkg::IDX_W'(pos);
         end
      end
   end

   // zero quantum acts as one; FCFS runs the whole burst
   assign q_eff   = (quantum_ff == '0) ? rrbs_pkg::QUANTUM_W'(1) : quantum_ff;
   assign cur_rem = rem_ff[cur_ff];
   assign amt     = (mode_ff != rrbs_pkg::MODE_FCFS && q_eff < cur_rem) ? q_eff : cur_rem;

   assign next_start = (cur_ff == rrbs_pkg::IDX_W'(rrbs_pkg::MAX_PROCS - 1)) ?
                       '0 : cur_ff + 1'b1;

   always_comb begin
      for (int i = 0; i < rrbs_pkg::MAX_PROCS; i++) begin
         wait_sum[i] = {1'b0, wait_ff[i]} + (rrbs_pkg::WAIT_W + 1)'(amt);
      end
   end

   assign last_idx = (rrbs_pkg::CNT_W'(out_idx_ff) + 1'b1) == count_ff;

   assign status.found    = found;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.last_idx = last_idx;

   always_comb begin
      rem_in       = rem_ff;
      wait_in      = wait_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      out_idx_in   = out_idx_ff;
      clk_in       = clk_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // items past a full batch are dropped
      if (cmd.load && count_ff < rrbs_pkg::CNT_W'(rrbs_pkg::MAX_PROCS)) begin
         rem_in[count_ff[rrbs_pkg::IDX_W-1:0]]  = req_data.burst;
         wait_in[count_ff[rrbs_pkg::IDX_W-1:0]] = '0;
         count_in = count_ff + 1'b1;
      end
      if (cmd.start) begin
         clk_in     = '0;
         start_in   = '0;
         out_idx_in = '0;
      end
      if (cmd.pick) begin
         cur_in = found_idx;
      end
      if (cmd.run) begin
         rem_in[cur_ff] = cur_rem - amt;
         for (int i = 0; i < rrbs_pkg::MAX_PROCS; i++) begin
            if (rrbs_pkg::IDX_W'(i) != cur_ff && active[i]) begin
               wait_in[i] = wait_sum[i][rrbs_pkg::WAIT_W] ? '1 :
                            wait_sum[i][rrbs_pkg::WAIT_W-1:0];
            end
         end
         clk_in   = clk_ff + rrbs_pkg::ELAPSED_W'(amt);
         start_in = next_start;
      end
      if (cmd.emit) begin
         rsp_in.pid         = rrbs_pkg::PID_W'(out_idx_ff);
         rsp_in.wait_total  = wait_ff[out_idx_ff];
         rsp_in.elapsed     = last_idx ? clk_ff : '0;
         rsp_in.last_result = last_idx;
         rsp_valid_in       = 1'b1;
         out_idx_in         = out_idx_ff + 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      quantum_in = quantum_ff;
      if (csr_we) begin
         case (csr_index)
            rrbs_pkg::CSR_SCHED_MODE: begin
               mode_in = csr_wdata[0];
            end
            rrbs_pkg::CSR_QUANTUM: begin
               quantum_in = csr_wdata[rrbs_pkg::QUANTUM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      wait_ff <= wait_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cur_ff       <= '0;
         start_ff     <= '0;
         out_idx_ff   <= '0;
         clk_ff       <= '0;
         mode_ff      <= rrbs_pkg::MODE_RESET;
         quantum_ff   <= rrbs_pkg::QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         out_idx_ff   <= out_idx_in;
         clk_ff       <= clk_in;
         mode_ff      <= mode_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RRBS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
      count_ff <= rrbs_pkg::CNT_W'(rrbs_pkg::MAX_PROCS))
   `RRBS_ASSERT_IMPLY(a_run_active, clock, reset, cmd.run, active[cur_ff])
   `RRBS_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit,
      !rsp_valid_ff || !rsp_stall)

endmodule

// ----- rtl/rrbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrbs_ctrl
// Sequencer: load, pick/run slice loop, then result drain.
// ----------------------------------------------------------------------------
`include "round_robin_burst_scheduler_defines.svh"

module rrbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_stall,
   input  rrbs_pkg::status_type  status,
   output rrbs_pkg::cmd_type     cmd
);

   rrbs_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         rrbs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.start = 1'b1;
                  state_in  = rrbs_pkg::ST_PICK;
               end
            end
         end
         rrbs_pkg::ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = status.found ? rrbs_pkg::ST_RUN : rrbs_pkg::ST_EMIT;
         end
         rrbs_pkg::ST_RUN: begin
            cmd.run  = 1'b1;
            state_in = rrbs_pkg::ST_PICK;
         end
         rrbs_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_idx) begin
                  cmd.clear = 1'b1;
                  state_in  = rrbs_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rrbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `RRBS_ASSERT_NEXT(a_pick_done, clock, reset,
      state_ff == rrbs_pkg::ST_PICK && !status.found, state_ff == rrbs_pkg::ST_EMIT)

endmodule

// ----- rtl/round_robin_burst_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_burst_scheduler
// Batch CPU scheduler, round robin with quantum or run to completion.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one process burst per transfer; pids follow arrival order.
//  The transfer with last_proc set closes the batch and starts scheduling.
//  Bursts past MAX_PROCS in one batch are dropped.
//  rsp_* returns one transfer per process in pid order with its total wait;
//  the final one carries elapsed time and last_result.
//  csr_* writes sched_mode (index 0) and quantum (index 1); the user must
//  do so only while idle, the block itself does not enforce it.
// Timing:
//  Bursts before the final one are taken while idle. After the final burst
//  the slice loop alternates a search for the next unfinished entry with
//  the slice update and ends with a closing search; then results load into
//  the output register while it is free. req_stall is high from the final
//  burst until the last result is loaded. A stalled result holds in the
//  output register; the drain simply waits. Reset clears the batch, sets
//  round-robin mode with quantum 4 and drops any pending result.
// ----------------------------------------------------------------------------
module round_robin_burst_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rrbs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rrbs_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [rrbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rrbs_pkg::cmd_type    cmd;
   rrbs_pkg::status_type status;

   rrbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_proc),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rrbs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
